// ----- src/dht_pkg.sv -----
package dht_pkg;

   localparam int unsigned PHASE_W    = 7;
   localparam int unsigned TICK_W     = 8;
   localparam int unsigned START_W    = 16;
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [PHASE_W-1:0] PHASE_LAST       = 7'd82;
   localparam logic [PHASE_W-1:0] HANDSHAKE_PHASES = 7'd3;
   localparam logic [PHASE_W-1:0] HUM_LAST_PHASE   = 7'd34;
   localparam logic [PHASE_W-1:0] TEMP_LAST_PHASE  = 7'd66;

   localparam logic [TICK_W-1:0]  TICK_MAX  = 8'hFF;
   localparam logic [START_W-1:0] START_MAX = 16'hFFFF;

   localparam logic [TICK_W-1:0]  TIMEOUT_RESET   = 8'd90;
   localparam logic [TICK_W-1:0]  THRESHOLD_RESET = 8'd30;
   localparam logic [START_W-1:0] START_LOW_RESET = 16'd18000;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LOW = 2'd2;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_START = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [TICK_W-1:0]  timeout_ticks;
      logic [TICK_W-1:0]  one_threshold_ticks;
      logic [START_W-1:0] start_low_ticks;
   } cfg_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      logic              timeout_error;
      logic [WORD_W-1:0] humidity_word;
      logic [WORD_W-1:0] temperature_word;
   } rsp_type;

endpackage

// ----- src/dht_csr.sv -----
module dht_csr
   import dht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TIMEOUT:   cfg_in.timeout_ticks       = csr_data[TICK_W-1:0];
            CSR_THRESHOLD: cfg_in.one_threshold_ticks = csr_data[TICK_W-1:0];
            CSR_START_LOW: cfg_in.start_low_ticks     = csr_data[START_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks       <= TIMEOUT_RESET;
         cfg_ff.one_threshold_ticks <= THRESHOLD_RESET;
         cfg_ff.start_low_ticks     <= START_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/dht_core.sv -----
module dht_core
   import dht_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    func,
   input  logic    line_level,
   input  cfg_type cfg,
   output rsp_type rsp
);

   mode_type            mode_ff, mode_in;
   logic [PHASE_W-1:0]  phase_index_ff, phase_index_in;
   logic [TICK_W-1:0]   phase_ticks_ff, phase_ticks_in;
   logic [START_W-1:0]  start_ticks_ff, start_ticks_in;
   logic [WORD_W-1:0]   shift_word_ff, shift_word_in;
   logic [WORD_W-1:0]   humidity_capture_ff, humidity_capture_in;
   logic [WORD_W-1:0]   humidity_store_ff, humidity_store_in;
   logic [WORD_W-1:0]   temperature_store_ff, temperature_store_in;
   logic                done;
   logic                err;
   logic [START_W:0]    start_next;
   logic                expect_high;
   logic                data_high_phase;
   logic [WORD_W-1:0]   shifted;

   assign start_next      = {1'b0, start_ticks_ff} + {{START_W{1'b0}}, 1'b1};
   // even phases expect high, odd ones low
   assign expect_high     = ~phase_index_ff[0];
   assign data_high_phase = (phase_index_ff >= HANDSHAKE_PHASES) && !phase_index_ff[0]
                            && (phase_index_ff <= TEMP_LAST_PHASE);
   assign shifted         = {shift_word_ff[WORD_W-2:0],
                             (phase_ticks_ff > cfg.one_threshold_ticks)};

   // next state
   always_comb begin
      mode_in              = mode_ff;
      phase_index_in       = phase_index_ff;
      phase_ticks_in       = phase_ticks_ff;
      start_ticks_in       = start_ticks_ff;
      shift_word_in        = shift_word_ff;
      humidity_capture_in  = humidity_capture_ff;
      humidity_store_in    = humidity_store_ff;
      temperature_store_in = temperature_store_ff;
      done                 = 1'b0;
      err                  = 1'b0;
      if (step) begin
         if (func) begin
            if (mode_ff != MODE_START && mode_ff != MODE_READ) begin
               mode_in             = MODE_START;
               start_ticks_in      = '0;
               phase_index_in      = '0;
               phase_ticks_in      = '0;
               shift_word_in       = '0;
               humidity_capture_in = '0;
            end
         end else begin
            case (mode_ff)
               MODE_START: begin
                  if (start_next >= {1'b0, cfg.start_low_ticks}) begin
                     mode_in        = MODE_READ;
                     phase_index_in = '0;
                     phase_ticks_in = '0;
                  end
                  start_ticks_in = start_next[START_W] ? START_MAX : start_next[START_W-1:0];
               end
               MODE_READ: begin
                  if (phase_ticks_ff > cfg.timeout_ticks) begin
                     mode_in = MODE_IDLE;
                     err     = 1'b1;
                  end else if (line_level == expect_high) begin
                     if (phase_ticks_ff != TICK_MAX) begin
                        phase_ticks_in = phase_ticks_ff + 8'd1;
                     end
                  end else begin
                     if (data_high_phase) begin
                        shift_word_in = shifted;
                        if (phase_index_ff == HUM_LAST_PHASE) begin
                           humidity_capture_in = shifted;
                        end
                     end
                     phase_ticks_in = '0;
                     if (phase_index_ff >= PHASE_LAST) begin
                        humidity_store_in    = humidity_capture_ff;
                        temperature_store_in = shift_word_ff;
                        mode_in              = MODE_IDLE;
                        phase_index_in       = '0;
                        done                 = 1'b1;
                     end else begin
                        phase_index_in = phase_index_ff + 7'd1;
                     end
                  end
               end
               default: mode_in = MODE_IDLE;
            endcase
         end
      end
   end

   // result word describes the state after this step
   always_comb begin
      rsp.drive_low        = (mode_in == MODE_START);
      rsp.busy_res         = (mode_in == MODE_START) || (mode_in == MODE_READ);
      rsp.done_res         = done;
      rsp.timeout_error    = err;
      rsp.humidity_word    = humidity_store_in;
      rsp.temperature_word = temperature_store_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff              <= MODE_IDLE;
         phase_index_ff       <= '0;
         phase_ticks_ff       <= '0;
         start_ticks_ff       <= '0;
         shift_word_ff        <= '0;
         humidity_capture_ff  <= '0;
         humidity_store_ff    <= '0;
         temperature_store_ff <= '0;
      end else begin
         mode_ff              <= mode_in;
         phase_index_ff       <= phase_index_in;
         phase_ticks_ff       <= phase_ticks_in;
         start_ticks_ff       <= start_ticks_in;
         shift_word_ff        <= shift_word_in;
         humidity_capture_ff  <= humidity_capture_in;
         humidity_store_ff    <= humidity_store_in;
         temperature_store_ff <= temperature_store_in;
      end
   end

endmodule

// ----- src/dht_out_buf.sv -----
module dht_out_buf
   import dht_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop       = main_valid_ff && rsp_ready;
   assign space     = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (load) begin
         if (!main_valid_ff || pop) begin
            main_in       = load_data;
            main_valid_in = 1'b1;
         end else begin
            // word waits behind the one on the port
            skid_in       = load_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- src/dht_single_wire_sensor_reader.sv -----
// Reader for a single-wire humidity and temperature sensor. Each request word is either one
// microsecond tick carrying a sample of the data line, or a read request; every word gives
// exactly one result word describing the block's state after it: whether the line is being
// pulled low, whether a read is in progress, a done or timeout flag for that word, and the last
// good humidity and temperature words. A word is taken every cycle while the output buffer
// has space; its result, set by the state update, is registered in that two-word buffer,
// which keeps requests flowing while a result waits on the response port. Registers: 0 timeout
// ticks, 1 one-bit threshold ticks, 2 start pulse length in ticks; write them while idle.
module dht_single_wire_sensor_reader
   import dht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic                  req_line_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_drive_low,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_timeout_error,
   output logic [WORD_W-1:0]     rsp_humidity_word,
   output logic [WORD_W-1:0]     rsp_temperature_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;
   rsp_type step_rsp;
   rsp_type out_rsp;
   logic    space;
   logic    step;

   assign req_ready = space;
   assign step      = req_valid && space;

   dht_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dht_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .func       (req_func),
      .line_level (req_line_level),
      .cfg        (cfg),
      .rsp        (step_rsp)
   );

   dht_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .load_data (step_rsp),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_rsp)
   );

   assign rsp_drive_low        = out_rsp.drive_low;
   assign rsp_busy_res         = out_rsp.busy_res;
   assign rsp_done_res         = out_rsp.done_res;
   assign rsp_timeout_error    = out_rsp.timeout_error;
   assign rsp_humidity_word    = out_rsp.humidity_word;
   assign rsp_temperature_word = out_rsp.temperature_word;

endmodule
